@@ rtl/mlp_sigmoid_inference_macros.svh @@
// ---------------------------------------------------------------------------
// MLP sigmoid inference assertion macros
// Shared concurrent assertion forms, clocked on clk and off during rst.
// ---------------------------------------------------------------------------
`ifndef MLP_SIGMOID_INFERENCE_MACROS_SVH
`define MLP_SIGMOID_INFERENCE_MACROS_SVH

// consequent checked in the same cycle
`define MSI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define MSI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/msi_pkg.sv @@
// ---------------------------------------------------------------------------
// MLP sigmoid inference package
// Field widths, operation and register codes, sigmoid lookup table.
// ---------------------------------------------------------------------------
package msi_pkg;

  localparam int VALUE_W        = 16;
  localparam int ACT_W          = 13;
  localparam int OP_W           = 2;
  localparam int SEL_W          = 2;
  localparam int IDX_W          = 4;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 5;
  localparam int LC_W           = 3;
  localparam int SIZE_W         = 5;
  localparam int NUM_SIZE_REGS  = 4;
  localparam int PROD_W         = 30;
  localparam int FRAC_BITS      = 12;

  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_LOAD_WEIGHT = 2'd0;
  localparam op_t OP_LOAD_BIAS   = 2'd1;
  localparam op_t OP_LOAD_INPUT  = 2'd2;
  localparam op_t OP_RUN         = 2'd3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_LAYER_COUNT = 3'd0;
  localparam cfg_idx_t CFG_SIZE_ZERO   = 3'd1;
  localparam cfg_idx_t CFG_SIZE_ONE    = 3'd2;
  localparam cfg_idx_t CFG_SIZE_TWO    = 3'd3;
  localparam cfg_idx_t CFG_SIZE_THREE  = 3'd4;

  // 4096 / (1 + exp(m/16)), rounded
  function automatic logic [ACT_W-1:0] sig_low(input logic [7:0] m);
    logic [ACT_W-1:0] r;
    case (m)
      8'd0: r = 13'd2048;   8'd1: r = 13'd1984;   8'd2: r = 13'd1920;
      8'd3: r = 13'd1857;   8'd4: r = 13'd1793;   8'd5: r = 13'd1731;
      8'd6: r = 13'd1668;   8'd7: r = 13'd1607;   8'd8: r = 13'd1546;
      8'd9: r = 13'd1487;   8'd10: r = 13'd1428;  8'd11: r = 13'd1370;
      8'd12: r = 13'd1314;  8'd13: r = 13'd1259;  8'd14: r = 13'd1205;
      8'd15: r = 13'd1153;  8'd16: r = 13'd1102;  8'd17: r = 13'd1052;
      8'd18: r = 13'd1004;  8'd19: r = 13'd957;   8'd20: r = 13'd912;
      8'd21: r = 13'd869;   8'd22: r = 13'd827;   8'd23: r = 13'd786;
      8'd24: r = 13'd747;   8'd25: r = 13'd710;   8'd26: r = 13'd674;
      8'd27: r = 13'd639;   8'd28: r = 13'd606;   8'd29: r = 13'd575;
      8'd30: r = 13'd545;   8'd31: r = 13'd516;   8'd32: r = 13'd488;
      8'd33: r = 13'd462;   8'd34: r = 13'd437;   8'd35: r = 13'd413;
      8'd36: r = 13'd391;   8'd37: r = 13'd369;   8'd38: r = 13'd349;
      8'd39: r = 13'd329;   8'd40: r = 13'd311;   8'd41: r = 13'd293;
      8'd42: r = 13'd277;   8'd43: r = 13'd261;   8'd44: r = 13'd246;
      8'd45: r = 13'd232;   8'd46: r = 13'd219;   8'd47: r = 13'd206;
      8'd48: r = 13'd194;   8'd49: r = 13'd183;   8'd50: r = 13'd172;
      8'd51: r = 13'd162;   8'd52: r = 13'd153;   8'd53: r = 13'd144;
      8'd54: r = 13'd136;   8'd55: r = 13'd128;   8'd56: r = 13'd120;
      8'd57: r = 13'd113;   8'd58: r = 13'd106;   8'd59: r = 13'd100;
      8'd60: r = 13'd94;    8'd61: r = 13'd89;    8'd62: r = 13'd83;
      8'd63: r = 13'd78;    8'd64: r = 13'd74;    8'd65: r = 13'd69;
      8'd66: r = 13'd65;    8'd67: r = 13'd61;    8'd68: r = 13'd58;
      8'd69: r = 13'd54;    8'd70: r = 13'd51;    8'd71: r = 13'd48;
      8'd72: r = 13'd45;    8'd73: r = 13'd42;    8'd74: r = 13'd40;
      8'd75: r = 13'd37;    8'd76: r = 13'd35;    8'd77: r = 13'd33;
      8'd78: r = 13'd31;    8'd79: r = 13'd29;    8'd80: r = 13'd27;
      8'd81: r = 13'd26;    8'd82: r = 13'd24;    8'd83: r = 13'd23;
      8'd84: r = 13'd21;    8'd85: r = 13'd20;    8'd86: r = 13'd19;
      8'd87: r = 13'd18;    8'd88: r = 13'd17;    8'd89: r = 13'd16;
      8'd90: r = 13'd15;    8'd91: r = 13'd14;    8'd92: r = 13'd13;
      8'd93: r = 13'd12;    8'd94: r = 13'd11;    8'd95: r = 13'd11;
      8'd96: r = 13'd10;    8'd97: r = 13'd10;    8'd98: r = 13'd9;
      8'd99: r = 13'd8;     8'd100: r = 13'd8;    8'd101: r = 13'd7;
      8'd102: r = 13'd7;    8'd103: r = 13'd7;    8'd104: r = 13'd6;
      8'd105: r = 13'd6;    8'd106: r = 13'd5;    8'd107: r = 13'd5;
      8'd108: r = 13'd5;    8'd109: r = 13'd5;    8'd110: r = 13'd4;
      8'd111: r = 13'd4;    8'd112: r = 13'd4;    8'd113: r = 13'd4;
      8'd114: r = 13'd3;    8'd115: r = 13'd3;    8'd116: r = 13'd3;
      8'd117: r = 13'd3;    8'd118: r = 13'd3;    8'd119: r = 13'd2;
      8'd120: r = 13'd2;    8'd121: r = 13'd2;    8'd122: r = 13'd2;
      8'd123: r = 13'd2;    8'd124: r = 13'd2;    8'd125: r = 13'd2;
      8'd126: r = 13'd2;    8'd127: r = 13'd1;    8'd128: r = 13'd1;
      default: r = 13'd1;
    endcase
    return r;
  endfunction

  // idx = (s >> 8) + 128
  function automatic logic [ACT_W-1:0] sigmoid_lut(input logic [7:0] idx);
    logic [7:0]       m;
    logic [ACT_W-1:0] lo;
    m  = idx[7] ? (idx - 8'd128) : (8'd128 - idx);
    lo = sig_low(m);
    return idx[7] ? (13'd4096 - lo) : lo;
  endfunction

endpackage

@@ rtl/msi_ram.sv @@
// ---------------------------------------------------------------------------
// MSI generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module msi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/mlp_sigmoid_inference.sv @@
// ---------------------------------------------------------------------------
// MLP sigmoid inference
// Fully connected Q4.12 forward pass, table sigmoid, one shared MAC.
// ---------------------------------------------------------------------------
// For each layer a run computes the activations, then, if another layer follows,
// the weighted sums into it; the last layer's outputs are then presented. A run's
// length is set mostly by the single MAC reading one weight word per cycle.
// Reset is synchronous: clears control, sets two layers of 16 nodes; the weight,
// bias, input and activation memories are not initialized.
module mlp_sigmoid_inference #(
  parameter int MAX_LAYERS = 4,
  parameter int MAX_NODES  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [msi_pkg::OP_W-1:0]              operation,
  input  logic [msi_pkg::SEL_W-1:0]             layer_sel,
  input  logic [msi_pkg::IDX_W-1:0]             row_sel,
  input  logic [msi_pkg::IDX_W-1:0]             col_sel,
  input  logic signed [msi_pkg::VALUE_W-1:0]    value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [msi_pkg::IDX_W-1:0]             node_index,
  output logic [msi_pkg::ACT_W-1:0]             activation_out,
  output logic                                  last,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [msi_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [msi_pkg::CFG_DATA_W-1:0]        cfg_data
);

  import msi_pkg::*;

  localparam int NODE_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W      = $clog2(MAX_NODES + 1);
  localparam int B_DEPTH    = MAX_LAYERS * MAX_NODES;
  localparam int B_AW       = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int W_DEPTH    = (MAX_LAYERS > 1) ? (MAX_LAYERS - 1) * MAX_NODES * MAX_NODES : 1;
  localparam int W_AW       = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int ACC_W      = PROD_W + CNT_W;
  localparam int RUN_LAYERS = (MAX_LAYERS < NUM_SIZE_REGS) ? MAX_LAYERS : NUM_SIZE_REGS;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ACT  = 4'b0010,
    S_MAC  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;

  logic [LC_W-1:0]   layer_count;
  logic [SIZE_W-1:0] size_layer_zero, size_layer_one, size_layer_two, size_layer_three;

  logic [SEL_W-1:0]  layer;
  logic [CNT_W-1:0]  cnt, col;
  logic              issue_done;

  logic              a_valid;
  logic [NODE_W-1:0] a_idx;
  logic              d_valid, d_first, d_last;
  logic [NODE_W-1:0] d_col;
  logic              p_valid, p_first, p_last;
  logic [NODE_W-1:0] p_col;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc, fin;
  logic              fin_valid;
  logic [NODE_W-1:0] fin_col;
  logic              pend, o_last;
  logic [CNT_W-1:0]  o_idx;

  function automatic logic [CNT_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    if (v == '0) return CNT_W'(1);
    else if (int'(v) > MAX_NODES) return CNT_W'(MAX_NODES);
    else return CNT_W'(v);
  endfunction

  function automatic logic [CNT_W-1:0] sel_size(input logic [SEL_W-1:0] l,
                                                input logic [SIZE_W-1:0] s0,
                                                input logic [SIZE_W-1:0] s1,
                                                input logic [SIZE_W-1:0] s2,
                                                input logic [SIZE_W-1:0] s3);
    logic [SIZE_W-1:0] v;
    unique case (l)
      2'd0:    v = s0;
      2'd1:    v = s1;
      2'd2:    v = s2;
      default: v = s3;
    endcase
    return clamp_size(v);
  endfunction

  logic [CNT_W-1:0] sz_cur, sz_nxt;
  logic [LC_W-1:0]  layers_eff;
  logic             more_layers;
  logic             accept_in, take;

  assign sz_cur = sel_size(layer, size_layer_zero, size_layer_one, size_layer_two,
                           size_layer_three);
  assign sz_nxt = sel_size(layer + 2'd1, size_layer_zero, size_layer_one, size_layer_two,
                           size_layer_three);

  always_comb begin
    if (layer_count == '0) layers_eff = LC_W'(1);
    else if (int'(layer_count) > RUN_LAYERS) layers_eff = LC_W'(RUN_LAYERS);
    else layers_eff = layer_count;
  end

  assign more_layers = ({1'b0, layer} + 3'd1) < layers_eff;
  assign in_stall    = (state != S_IDLE);
  assign accept_in   = in_valid && !in_stall;
  assign take        = out_valid && !out_stall;
  assign cfg_ready   = 1'b1;

  // memories
  logic               w_we, b_we, i_we;
  logic [W_AW-1:0]    w_waddr, w_raddr;
  logic [B_AW-1:0]    b_waddr, b_raddr;
  logic [VALUE_W-1:0] w_rdata, b_rdata, i_rdata, k_rdata, k_wdata;
  logic [ACT_W-1:0]   act_rdata, act_wdata;
  logic [NODE_W-1:0]  act_raddr;

  assign w_we = accept_in && operation == OP_LOAD_WEIGHT && (int'(layer_sel) + 1 < MAX_LAYERS)
                && int'(row_sel) < MAX_NODES && int'(col_sel) < MAX_NODES;
  assign b_we = accept_in && operation == OP_LOAD_BIAS && int'(layer_sel) < MAX_LAYERS
                && int'(row_sel) < MAX_NODES;
  assign i_we = accept_in && operation == OP_LOAD_INPUT && int'(row_sel) < MAX_NODES;

  assign w_waddr = W_AW'((int'(layer_sel) * MAX_NODES + int'(row_sel)) * MAX_NODES
                         + int'(col_sel));
  assign w_raddr = W_AW'((int'(layer) * MAX_NODES + int'(cnt)) * MAX_NODES + int'(col));
  assign b_waddr = B_AW'(int'(layer_sel) * MAX_NODES + int'(row_sel));
  assign b_raddr = B_AW'(int'(layer) * MAX_NODES + int'(cnt));
  assign act_raddr = cnt[NODE_W-1:0];

  msi_ram #(.WIDTH(VALUE_W), .DEPTH(W_DEPTH)) u_weight (
    .clk, .we(w_we), .waddr(w_waddr), .wdata(value), .raddr(w_raddr), .rdata(w_rdata)
  );
  msi_ram #(.WIDTH(VALUE_W), .DEPTH(B_DEPTH)) u_bias (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(value), .raddr(b_raddr), .rdata(b_rdata)
  );
  msi_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_NODES)) u_input (
    .clk, .we(i_we), .waddr(NODE_W'(row_sel)), .wdata(value), .raddr(cnt[NODE_W-1:0]),
    .rdata(i_rdata)
  );
  msi_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_NODES)) u_work (
    .clk, .we(fin_valid), .waddr(fin_col), .wdata(k_wdata), .raddr(cnt[NODE_W-1:0]),
    .rdata(k_rdata)
  );
  msi_ram #(.WIDTH(ACT_W), .DEPTH(MAX_NODES)) u_act (
    .clk, .we(a_valid), .waddr(a_idx), .wdata(act_wdata), .raddr(act_raddr),
    .rdata(act_rdata)
  );

  // bias add, saturate, sigmoid
  logic [VALUE_W-1:0]        src, s_sat;
  logic signed [VALUE_W:0]   nsum;

  always_comb begin
    src  = (layer == '0) ? i_rdata : k_rdata;
    nsum = $signed({src[VALUE_W-1], src}) + $signed({b_rdata[VALUE_W-1], b_rdata});
    if (nsum[VALUE_W] != nsum[VALUE_W-1]) begin
      s_sat = nsum[VALUE_W] ? 16'h8000 : 16'h7fff;
    end else begin
      s_sat = nsum[VALUE_W-1:0];
    end
    act_wdata = sigmoid_lut(s_sat[15:8] ^ 8'h80);
  end

  // accumulate, then floor shift and saturate
  logic signed [ACC_W-1:0] acc_sum, q;

  always_comb begin
    acc_sum = (p_first ? '0 : acc) + ACC_W'(prod);
    q       = fin >>> FRAC_BITS;
    if (q > SAT_HI) k_wdata = 16'h7fff;
    else if (q < SAT_LO) k_wdata = 16'h8000;
    else k_wdata = q[VALUE_W-1:0];
  end

  always_ff @(posedge clk) begin
    d_first <= (cnt == '0);
    d_last  <= (cnt == sz_cur - 1'b1);
    d_col   <= col[NODE_W-1:0];
    a_idx   <= cnt[NODE_W-1:0];
    prod    <= $signed({1'b0, act_rdata}) * $signed(w_rdata);
    p_first <= d_first;
    p_last  <= d_last;
    p_col   <= d_col;
    if (p_valid) begin
      acc <= acc_sum;
    end
    if (p_valid && p_last) begin
      fin     <= acc_sum;
      fin_col <= p_col;
    end
    if (pend) begin
      node_index     <= IDX_W'(o_idx);
      activation_out <= act_rdata;
      last           <= o_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      layer_count      <= LC_W'(2);
      size_layer_zero  <= SIZE_W'(16);
      size_layer_one   <= SIZE_W'(16);
      size_layer_two   <= SIZE_W'(16);
      size_layer_three <= SIZE_W'(16);
      layer            <= '0;
      cnt              <= '0;
      col              <= '0;
      issue_done       <= 1'b0;
      a_valid          <= 1'b0;
      d_valid          <= 1'b0;
      p_valid          <= 1'b0;
      fin_valid        <= 1'b0;
      pend             <= 1'b0;
      o_idx            <= '0;
      o_last           <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_LAYER_COUNT: layer_count      <= cfg_data[LC_W-1:0];
          CFG_SIZE_ZERO:   size_layer_zero  <= cfg_data;
          CFG_SIZE_ONE:    size_layer_one   <= cfg_data;
          CFG_SIZE_TWO:    size_layer_two   <= cfg_data;
          CFG_SIZE_THREE:  size_layer_three <= cfg_data;
          default: ;
        endcase
      end

      a_valid   <= (state == S_ACT) && !issue_done;
      d_valid   <= (state == S_MAC) && !issue_done;
      p_valid   <= d_valid;
      fin_valid <= p_valid && p_last;

      if (pend) begin
        out_valid <= 1'b1;
      end else if (take) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept_in && operation == OP_RUN) begin
            state      <= S_ACT;
            layer      <= '0;
            cnt        <= '0;
            issue_done <= 1'b0;
          end
        end
        S_ACT: begin
          if (!issue_done) begin
            if (cnt == sz_cur - 1'b1) issue_done <= 1'b1;
            else cnt <= cnt + 1'b1;
          end else if (!a_valid) begin
            state      <= more_layers ? S_MAC : S_OUT;
            cnt        <= '0;
            col        <= '0;
            issue_done <= 1'b0;
            pend       <= 1'b0;
          end
        end
        S_MAC: begin
          if (!issue_done) begin
            if (cnt == sz_cur - 1'b1) begin
              cnt <= '0;
              if (col == sz_nxt - 1'b1) issue_done <= 1'b1;
              else col <= col + 1'b1;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end else if (!d_valid && !p_valid && !fin_valid) begin
            state      <= S_ACT;
            layer      <= layer + 1'b1;
            cnt        <= '0;
            issue_done <= 1'b0;
          end
        end
        S_OUT: begin
          if (pend) begin
            pend <= 1'b0;
          end else if (!out_valid || take) begin
            if (!issue_done) begin
              pend   <= 1'b1;
              o_idx  <= cnt;
              o_last <= (cnt == sz_cur - 1'b1);
              if (cnt == sz_cur - 1'b1) issue_done <= 1'b1;
              else cnt <= cnt + 1'b1;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/msi_checker.sv @@
// ---------------------------------------------------------------------------
// MSI port checker
// Port-level temporal checks, bound to the top level.
// ---------------------------------------------------------------------------
`include "mlp_sigmoid_inference_macros.svh"

module msi_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [msi_pkg::OP_W-1:0]      operation,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [msi_pkg::ACT_W-1:0]     activation_out,
  input logic                          last
);

  import msi_pkg::*;

  `MSI_ASSERT_NEXT(a_run_busy, in_valid && !in_stall && operation == OP_RUN, in_stall, "run transaction did not block input")
  `MSI_ASSERT_SAME(a_out_busy, out_valid, in_stall, "input accepted while a result is pending")
  `MSI_ASSERT_NEXT(a_last_end, out_valid && !out_stall && last, !out_valid, "result after last of run")
  `MSI_ASSERT_SAME(a_act_range, out_valid, activation_out <= 13'd4096, "activation above one")
  `MSI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(activation_out) && $stable(last), "stalled result changed")

endmodule

bind mlp_sigmoid_inference msi_checker u_msi_checker (.*);
